>>> design/tpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared codes, widths and types of the triangle primitive assembler.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int unsigned CoordBitsDefault  = 32;
  localparam int unsigned CountBitsDefault  = 16;
  localparam int unsigned QueueDepthDefault = 4;

  // Width of the coordinate words on the channels.
  localparam int unsigned WordBits = 32;

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_END      = 2'd1,
    OP_POSITION = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  localparam logic [7:0] PRIM_QUADS = 8'h80;
  localparam logic [7:0] PRIM_LIST  = 8'h90;
  localparam logic [7:0] PRIM_STRIP = 8'h98;
  localparam logic [7:0] PRIM_FAN   = 8'hA0;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> design/tpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_cmd_if / tpa_tri_if
// Valid/ready channels for command words and for triangle words.
// ----------------------------------------------------------------------------
interface tpa_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  primitive_req;
  logic [15:0] vtx_total;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;

  modport source (
    output valid, operation, primitive_req, vtx_total, coord_x, coord_y, coord_z,
    input  ready
  );
  modport sink (
    input  valid, operation, primitive_req, vtx_total, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

interface tpa_tri_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_x;
  logic [31:0] a_y;
  logic [31:0] a_z;
  logic [31:0] b_x;
  logic [31:0] b_y;
  logic [31:0] b_z;
  logic [31:0] c_x;
  logic [31:0] c_y;
  logic [31:0] c_z;
  logic        final_of_run;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_of_run,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_of_run,
    output ready
  );
endinterface

>>> design/triangle_primitive_assembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_primitive_assembler_unit
// Assembles list, strip, fan and quad vertex streams into triangles.
// ----------------------------------------------------------------------------
//  Port   | Dir | Word
//  -------+-----+--------------------------------------------------------
//  cmd_i  | in  | operation, primitive code, vertex count, x/y/z words
//  tri_o  | out | three corners of x/y/z words, final_of_run flag
//
//  A command word is taken in every cycle while the job queue has room.
//  A triangle's job is registered in the job queue with its vertex; a quad
//  pair leaves the back end as two triangle words, buffered by the job queue.
//  Reset clears the draw state and empties the queue.
//  A stall at tri_o fills the queue and then holds cmd_i.ready low.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_unit #(
  parameter int unsigned COORD_BITS  = tpa_pkg::CoordBitsDefault,
  parameter int unsigned COUNT_BITS  = tpa_pkg::CountBitsDefault,
  parameter int unsigned QUEUE_DEPTH = tpa_pkg::QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpa_cmd_if.sink   cmd_i,
  tpa_tri_if.source tri_o
);
  import tpa_pkg::*;

  localparam int unsigned JobBits = 1 + 12 * COORD_BITS;

  logic               push;
  logic               pop;
  logic [JobBits-1:0] job_in;
  logic [JobBits-1:0] job_head;
  queue_status_t      q_status;

  tpa_front #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .JOB_BITS   (JobBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_in)
  );

  tpa_queue #(
    .WIDTH (JobBits),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .pop_i    (pop),
    .data_o   (job_head),
    .status_o (q_status)
  );

  tpa_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_BITS   (JobBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .tri_o      (tri_o)
  );

endmodule

>>> design/tpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_front
// Takes command words, keeps the draw state and the recent vertices, and
// pushes one job per emitting position into the triangle queue.
// ----------------------------------------------------------------------------
module tpa_front #(
  parameter int unsigned COORD_BITS = tpa_pkg::CoordBitsDefault,
  parameter int unsigned COUNT_BITS = tpa_pkg::CountBitsDefault,
  parameter int unsigned JOB_BITS   = 1 + 12 * COORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tpa_cmd_if.sink                     cmd_i,
  input  tpa_pkg::queue_status_t      q_status_i,
  output logic                        push_o,
  output logic [JOB_BITS-1:0]         job_o
);
  import tpa_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic    pair;
    vertex_t v0;
    vertex_t v1;
    vertex_t v2;
    vertex_t v3;
  } job_t;

  logic                  active_q, active_d;
  logic [7:0]            kind_q, kind_d;
  logic [COUNT_BITS-1:0] expected_q, expected_d;
  logic [COUNT_BITS-1:0] accepted_q, accepted_d;
  logic [1:0]            mod3_q, mod3_d;
  vertex_t               origin_q, p1_q, p2_q, p3_q;

  logic                  accept;
  logic                  take_vertex;
  logic [COUNT_BITS-1:0] n_next;
  logic [1:0]            mod3_next;
  vertex_t               cur;
  job_t                  job;
  logic                  emit;
  op_e                   op;

  assign cmd_i.ready = ~q_status_i.full;
  assign accept      = cmd_i.valid & cmd_i.ready;
  assign op          = op_e'(cmd_i.operation);

  assign cur.x = COORD_BITS'(cmd_i.coord_x);
  assign cur.y = COORD_BITS'(cmd_i.coord_y);
  assign cur.z = COORD_BITS'(cmd_i.coord_z);

  assign take_vertex = accept && (op == OP_POSITION) && active_q && (accepted_q < expected_q);
  assign n_next      = accepted_q + COUNT_BITS'(1);
  assign mod3_next   = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;

  // The vertex count starts at one for the first vertex of a draw, so the
  // parity of the new count picks the winding of a strip triangle.
  always_comb begin
    emit    = 1'b0;
    job     = '0;
    job.v3  = cur;
    case (kind_q)
      PRIM_LIST: begin
        emit   = (mod3_next == 2'd0);
        job.v0 = p2_q;
        job.v1 = p1_q;
        job.v2 = cur;
      end
      PRIM_STRIP: begin
        emit   = (n_next >= COUNT_BITS'(3));
        job.v0 = n_next[0] ? p2_q : p1_q;
        job.v1 = n_next[0] ? p1_q : p2_q;
        job.v2 = cur;
      end
      PRIM_FAN: begin
        emit   = (n_next >= COUNT_BITS'(3));
        job.v0 = origin_q;
        job.v1 = p1_q;
        job.v2 = cur;
      end
      PRIM_QUADS: begin
        emit     = (n_next[1:0] == 2'd0);
        job.pair = 1'b1;
        job.v0   = p3_q;
        job.v1   = p2_q;
        job.v2   = p1_q;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_o = take_vertex & emit;
  assign job_o  = job;

  always_comb begin
    active_d   = active_q;
    kind_d     = kind_q;
    expected_d = expected_q;
    accepted_d = accepted_q;
    mod3_d     = mod3_q;
    if (accept) begin
      unique case (op)
        OP_BEGIN: begin
          kind_d     = cmd_i.primitive_req;
          expected_d = COUNT_BITS'(cmd_i.vtx_total);
          active_d   = (COUNT_BITS'(cmd_i.vtx_total) != '0);
          accepted_d = '0;
          mod3_d     = 2'd0;
        end
        OP_END: begin
          active_d = 1'b0;
        end
        OP_CLEAR: begin
          active_d   = 1'b0;
          kind_d     = '0;
          expected_d = '0;
          accepted_d = '0;
          mod3_d     = 2'd0;
        end
        OP_POSITION: begin
          if (take_vertex) begin
            accepted_d = n_next;
            mod3_d     = mod3_next;
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      kind_q     <= '0;
      expected_q <= '0;
      accepted_q <= '0;
      mod3_q     <= 2'd0;
    end else begin
      active_q   <= active_d;
      kind_q     <= kind_d;
      expected_q <= expected_d;
      accepted_q <= accepted_d;
      mod3_q     <= mod3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_vertex) begin
      p3_q <= p2_q;
      p2_q <= p1_q;
      p1_q <= cur;
      if (accepted_q == '0) begin
        origin_q <= cur;
      end
    end
  end

endmodule

>>> design/tpa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_queue
// Short first-in first-out queue of triangle jobs between front and back.
// ----------------------------------------------------------------------------
module tpa_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = tpa_pkg::QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       data_o,
  output tpa_pkg::queue_status_t status_o
);
  import tpa_pkg::*;

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   entry_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign status_o.full  = (count_q == CntBits'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign data_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/tpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_back
// Turns the job at the head of the queue into one or two triangle words.
// ----------------------------------------------------------------------------
module tpa_back #(
  parameter int unsigned COORD_BITS = tpa_pkg::CoordBitsDefault,
  parameter int unsigned JOB_BITS   = 1 + 12 * COORD_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [JOB_BITS-1:0]    job_i,
  input  tpa_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  tpa_tri_if.source              tri_o
);
  import tpa_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic    pair;
    vertex_t v0;
    vertex_t v1;
    vertex_t v2;
    vertex_t v3;
  } job_t;

  job_t    job;
  vertex_t corner_b;
  vertex_t corner_c;
  logic    second_q, second_d;
  logic    handshake;

  assign job       = job_t'(job_i);
  assign handshake = tri_o.valid & tri_o.ready;

  // The second triangle of a quad keeps the first corner and moves on by one.
  assign corner_b = second_q ? job.v2 : job.v1;
  assign corner_c = second_q ? job.v3 : job.v2;

  assign tri_o.valid        = ~q_status_i.empty;
  assign tri_o.a_x          = WordBits'(job.v0.x);
  assign tri_o.a_y          = WordBits'(job.v0.y);
  assign tri_o.a_z          = WordBits'(job.v0.z);
  assign tri_o.b_x          = WordBits'(corner_b.x);
  assign tri_o.b_y          = WordBits'(corner_b.y);
  assign tri_o.b_z          = WordBits'(corner_b.z);
  assign tri_o.c_x          = WordBits'(corner_c.x);
  assign tri_o.c_y          = WordBits'(corner_c.y);
  assign tri_o.c_z          = WordBits'(corner_c.z);
  assign tri_o.final_of_run = ~job.pair | second_q;

  assign pop_o = handshake & (~job.pair | second_q);

  always_comb begin
    second_d = second_q;
    if (handshake) begin
      second_d = job.pair & ~second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

endmodule

>>> design/tpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_checker
// Port-level checks of the triangle output channel.
// ----------------------------------------------------------------------------
module tpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tri_valid_i,
  input logic        tri_ready_i,
  input logic [31:0] tri_a_x_i,
  input logic        tri_final_i
);

  // A stalled word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && !tri_ready_i |=> tri_valid_i)
    else $error("triangle word withdrawn while stalled");

  // A stalled word keeps the x word of its first corner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && !tri_ready_i |=> $stable(tri_a_x_i))
    else $error("triangle word changed while stalled");

  // The first triangle of a quad pair is always followed by its partner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && tri_ready_i && !tri_final_i |=> tri_valid_i && tri_final_i)
    else $error("quad partner triangle missing");

  // Both triangles of a quad share the x word of the first corner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && tri_ready_i && !tri_final_i |=> tri_a_x_i == $past(tri_a_x_i))
    else $error("quad triangles disagree on first corner");

endmodule

bind triangle_primitive_assembler_unit tpa_checker u_tpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tri_valid_i (tri_o.valid),
  .tri_ready_i (tri_o.ready),
  .tri_a_x_i   (tri_o.a_x),
  .tri_final_i (tri_o.final_of_run)
);
